// ----- hw/rtl/lprc_pkg.sv -----
// shared types, register indexes and arithmetic helpers of the lidar point repacker
`timescale 1ns / 1ps
package lprc_pkg;

   localparam int COORD_W     = 32;
   localparam int TIME_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int Q14_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int STAGES      = 5;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = 4;
   localparam int DIV10_SHIFT = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ROLL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ROLL      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_PITCH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_PITCH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR_ENABLE = 3'd4;

   localparam logic signed [Q14_W-1:0] Q14_ONE   = 16'sd16384;
   localparam logic signed [Q14_W-1:0] Q14_MONE  = -16'sd16384;
   localparam logic [FRAC_W-1:0]       FRAC_MAX  = 16'd6553;
   localparam logic [16:0]             DIV10_MUL = 17'd52429;
   localparam logic [13:0]             DIV7_MUL  = 14'd9363;

   typedef struct packed {
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
      logic [7:0]         scan_line;
      logic [7:0]         reflect_in;
      logic [31:0]        time_offset;
      logic [31:0]        frame_end_time;
      logic               last_point;
   } lprc_req_type;

   typedef struct packed {
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic signed [31:0] z_out;
      logic [23:0]        intensity_packed;
      logic [7:0]         reflect_out;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               frame_done;
   } lprc_rsp_type;

   typedef struct packed {
      logic [Q14_W-1:0] sin_roll;
      logic [Q14_W-1:0] cos_roll;
      logic [Q14_W-1:0] sin_pitch;
      logic [Q14_W-1:0] cos_pitch;
      logic             colour_enable;
   } lprc_csr_type;

   typedef struct packed {
      logic [TIME_W-1:0] rem;
      logic [FRAC_W-1:0] quo;
   } lprc_div_type;

   function automatic logic signed [Q14_W-1:0] clamp_q14(input logic [Q14_W-1:0] raw);
      logic signed [Q14_W-1:0] v;
      v = signed'(raw);
      if (v > Q14_ONE) begin
         return Q14_ONE;
      end else if (v < Q14_MONE) begin
         return Q14_MONE;
      end
      return v;
   endfunction

   function automatic logic signed [Q14_W-1:0] round_q14(input logic signed [33:0] p);
      logic signed [33:0] t;
      t = p + 34'sd8192;
      return t[29:14];
   endfunction

   function automatic lprc_div_type div_step(input lprc_div_type s,
                                             input logic [TIME_W-1:0] d);
      lprc_div_type       o;
      logic [TIME_W:0]    sh;
      sh = {s.rem, 1'b0};
      if (sh >= {1'b0, d}) begin
         o.rem = TIME_W'(sh - {1'b0, d});
         o.quo = {s.quo[FRAC_W-2:0], 1'b1};
      end else begin
         o.rem = sh[TIME_W-1:0];
         o.quo = {s.quo[FRAC_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // returns {red, green, blue}
   function automatic logic [23:0] colormap(input logic [7:0] r);
      logic [12:0] t;
      logic [10:0] x;
      logic [24:0] p;
      t = '0;
      x = '0;
      p = '0;
      if (r < 8'd30) begin
         t = 13'(r) * 13'd17;
         return {8'd0, t[8:1], 8'd255};
      end else if (r < 8'd90) begin
         t = 13'(8'd90 - r) * 13'd17;
         return {8'd0, 8'd255, t[9:2]};
      end else if (r < 8'd150) begin
         t = 13'(r - 8'd90) * 13'd17;
         return {t[9:2], 8'd255, 8'd0};
      end
      x = 11'(8'd255 - r) * 11'd17;
      p = 25'(x) * 25'(DIV7_MUL);
      return {8'd255, p[23:16], 8'd0};
   endfunction

endpackage

// ----- hw/rtl/lprc_rotate.sv -----
// extrinsic rotation pipeline with rounding and saturation
`timescale 1ns / 1ps
module lprc_rotate
   import lprc_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  lprc_csr_type              csr,
   input  logic signed [COORD_W-1:0] x_in,
   input  logic signed [COORD_W-1:0] y_in,
   input  logic signed [COORD_W-1:0] z_in,
   output logic signed [COORD_W-1:0] x_out,
   output logic signed [COORD_W-1:0] y_out,
   output logic signed [COORD_W-1:0] z_out
);

   logic signed [Q14_W-1:0] sr, cr, sp, cp;
   logic signed [Q14_W-1:0] m00_ff, m02_ff, m10_ff, m11_ff, m12_ff, m20_ff, m21_ff, m22_ff;
   logic signed [COORD_W-1:0] c_ff [3];
   logic signed [47:0] p_ff [8];
   logic signed [47:0] p_in [8];
   logic signed [35:0] s_ff [3];
   logic signed [35:0] s_in [3];
   logic signed [49:0] acc [3];
   logic signed [49:0] rnd [3];
   logic signed [COORD_W-1:0] q_ff [3];
   logic signed [COORD_W-1:0] q_in [3];
   logic signed [COORD_W-1:0] o_ff [3];

   assign sr = clamp_q14(csr.sin_roll);
   assign cr = clamp_q14(csr.cos_roll);
   assign sp = clamp_q14(csr.sin_pitch);
   assign cp = clamp_q14(csr.cos_pitch);

   always_ff @(posedge clock) begin
      m00_ff <= cp;
      m02_ff <= sp;
      m10_ff <= round_q14(34'(sr * sp));
      m11_ff <= cr;
      m12_ff <= round_q14(-34'(sr * cp));
      m20_ff <= round_q14(-34'(cr * sp));
      m21_ff <= sr;
      m22_ff <= round_q14(34'(cr * cp));
   end

   always_comb begin
      p_in[0] = 48'(m00_ff * c_ff[0]);
      p_in[1] = 48'(m02_ff * c_ff[2]);
      p_in[2] = 48'(m10_ff * c_ff[0]);
      p_in[3] = 48'(m11_ff * c_ff[1]);
      p_in[4] = 48'(m12_ff * c_ff[2]);
      p_in[5] = 48'(m20_ff * c_ff[0]);
      p_in[6] = 48'(m21_ff * c_ff[1]);
      p_in[7] = 48'(m22_ff * c_ff[2]);
   end

   always_comb begin
      acc[0] = 50'(p_ff[0]) + 50'(p_ff[1]);
      acc[1] = 50'(p_ff[2]) + 50'(p_ff[3]) + 50'(p_ff[4]);
      acc[2] = 50'(p_ff[5]) + 50'(p_ff[6]) + 50'(p_ff[7]);
      for (int i = 0; i < 3; i++) begin
         rnd[i]  = acc[i] + 50'sd8192;
         s_in[i] = rnd[i][49:14];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s_ff[i][35:31] == 5'b00000 || s_ff[i][35:31] == 5'b11111) begin
            q_in[i] = s_ff[i][31:0];
         end else if (s_ff[i][35]) begin
            q_in[i] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            q_in[i] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff[0] <= x_in;
         c_ff[1] <= y_in;
         c_ff[2] <= z_in;
         p_ff    <= p_in;
         s_ff    <= s_in;
         q_ff    <= q_in;
         o_ff    <= q_ff;
      end
   end

   assign x_out = o_ff[0];
   assign y_out = o_ff[1];
   assign z_out = o_ff[2];

endmodule

// ----- hw/rtl/lprc_time.sv -----
// time fraction divider pipeline and intensity packing
`timescale 1ns / 1ps
module lprc_time
   import lprc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [TIME_W-1:0] time_offset,
   input  logic [TIME_W-1:0] frame_end_time,
   input  logic [7:0]        scan_line,
   output logic [23:0]       intensity_packed
);

   lprc_div_type      d_ff [DIV_STAGES];
   lprc_div_type      d_in [DIV_STAGES];
   logic [TIME_W-1:0] e_ff [DIV_STAGES-1];
   logic [7:0]        l_ff [STAGES];
   logic              zero_ff [STAGES];
   logic              sat_ff [STAGES];
   logic [32:0]       prod_ff;
   lprc_div_type      s;
   logic [FRAC_W-1:0] frac;

   always_comb begin
      s.rem = time_offset;
      s.quo = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
         s = div_step(s, frame_end_time);
      end
      d_in[0] = s;
      for (int k = 1; k < DIV_STAGES; k++) begin
         s = d_ff[k-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            s = div_step(s, e_ff[k-1]);
         end
         d_in[k] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0]    <= frame_end_time;
         l_ff[0]    <= scan_line;
         zero_ff[0] <= (frame_end_time == '0);
         sat_ff[0]  <= (time_offset >= frame_end_time);
         for (int k = 1; k < DIV_STAGES-1; k++) begin
            e_ff[k] <= e_ff[k-1];
         end
         for (int k = 1; k < STAGES; k++) begin
            l_ff[k]    <= l_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
         d_ff    <= d_in;
         prod_ff <= 33'(d_ff[DIV_STAGES-1].quo) * 33'(DIV10_MUL);
      end
   end

   always_comb begin
      if (zero_ff[STAGES-1]) begin
         frac = '0;
      end else if (sat_ff[STAGES-1]) begin
         frac = FRAC_MAX;
      end else begin
         frac = FRAC_W'(prod_ff >> DIV10_SHIFT);
      end
   end

   assign intensity_packed = {l_ff[STAGES-1], frac};

endmodule

// ----- hw/rtl/lprc_colour.sv -----
// reflectivity colormap and its delay line
`timescale 1ns / 1ps
module lprc_colour
   import lprc_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  logic       colour_enable,
   input  logic [7:0] reflect_in,
   output logic [7:0] reflect_out,
   output logic [7:0] red,
   output logic [7:0] green,
   output logic [7:0] blue
);

   logic [31:0] c_ff [STAGES];
   logic [23:0] rgb;

   assign rgb = colour_enable ? colormap(reflect_in) : 24'd0;

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff[0] <= {reflect_in, rgb};
         for (int k = 1; k < STAGES; k++) begin
            c_ff[k] <= c_ff[k-1];
         end
      end
   end

   assign {reflect_out, red, green, blue} = c_ff[STAGES-1];

endmodule

// ----- hw/rtl/lidar_point_repack_rotate_colour.sv -----
// top level of the lidar point repacker: rotation, intensity packing, colormap
//
// req channel: one point per transfer (req_valid, req_stall, req_data).
// rsp channel: one result per point, in order (rsp_valid, rsp_stall, rsp_data).
// csr channel: csr_valid/csr_ready write of csr_wdata to register csr_index
//   (0 sin_roll, 1 cos_roll, 2 sin_pitch, 3 cos_pitch, 4 colour_enable);
//   other indexes are dropped. csr_ready is always high. write only while idle.
// rsp_valid is the last bit of the valid shift register v_ff, which shifts
//   with the data pipeline registers under the same advance.
// throughput: one point per cycle while rsp_stall does not hold the pipeline; the five-stage pipeline advances as one.
// the divider for the time fraction does four quotient bits per stage.
// while rsp_valid is high and rsp_stall is high the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.
// reset (synchronous, active high) empties the pipeline and restores the
//   identity rotation with color output off.
`timescale 1ns / 1ps
module lidar_point_repack_rotate_colour
   import lprc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lprc_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lprc_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   lprc_csr_type csr_ff;
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] last_ff;
   logic adv;

   assign csr_ready = 1'b1;
   assign adv       = !(v_ff[STAGES-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = v_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sin_roll      <= '0;
         csr_ff.cos_roll      <= Q14_ONE;
         csr_ff.sin_pitch     <= '0;
         csr_ff.cos_pitch     <= Q14_ONE;
         csr_ff.colour_enable <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIN_ROLL:      csr_ff.sin_roll      <= csr_wdata;
            CSR_COS_ROLL:      csr_ff.cos_roll      <= csr_wdata;
            CSR_SIN_PITCH:     csr_ff.sin_pitch     <= csr_wdata;
            CSR_COS_PITCH:     csr_ff.cos_pitch     <= csr_wdata;
            CSR_COLOUR_ENABLE: csr_ff.colour_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff <= {last_ff[STAGES-2:0], req_data.last_point};
      end
   end

   lprc_rotate u_rotate (
      .clock (clock),
      .en    (adv),
      .csr   (csr_ff),
      .x_in  (req_data.x_in),
      .y_in  (req_data.y_in),
      .z_in  (req_data.z_in),
      .x_out (rsp_data.x_out),
      .y_out (rsp_data.y_out),
      .z_out (rsp_data.z_out)
   );

   lprc_time u_time (
      .clock            (clock),
      .en               (adv),
      .time_offset      (req_data.time_offset),
      .frame_end_time   (req_data.frame_end_time),
      .scan_line        (req_data.scan_line),
      .intensity_packed (rsp_data.intensity_packed)
   );

   lprc_colour u_colour (
      .clock         (clock),
      .en            (adv),
      .colour_enable (csr_ff.colour_enable),
      .reflect_in    (req_data.reflect_in),
      .reflect_out   (rsp_data.reflect_out),
      .red           (rsp_data.red),
      .green         (rsp_data.green),
      .blue          (rsp_data.blue)
   );

   assign rsp_data.frame_done = last_ff[STAGES-1];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.intensity_packed[15:0] <= FRAC_MAX))
      else $error("time fraction above limit");

   a_bubble: assert property (@(posedge clock) disable iff (reset)
      (!req_stall && !v_ff[STAGES-2]) |=> !rsp_valid)
      else $error("result appeared from an empty stage");

endmodule

// ----- bench/testbench.sv -----
// testbench for the lidar point repacker: directed and random points checked against a predictor
`timescale 1ns / 1ps
module testbench;
   import lprc_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   lprc_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   lprc_rsp_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lprc_rsp_type pending_points[$];
   logic [15:0]  mount_sin_roll, mount_cos_roll, mount_sin_pitch, mount_cos_pitch;
   logic         colour_on;
   int           mismatch_count = 0;
   int           points_sent = 0;
   int           points_checked = 0;
   int           settings_used = 0;
   int           cycle_count = 0;
   bit           calm = 1'b0;

   lidar_point_repack_rotate_colour i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic longint clamp_angle(input logic [15:0] raw);
      longint v;
      v = longint'($signed(raw));
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v;
   endfunction

   function automatic longint q14_round(input longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic logic [31:0] saturate_coord(input longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic logic [15:0] time_frac(input logic [31:0] off, input logic [31:0] fin);
      longint unsigned q;
      if (fin == 0) return 16'd0;
      if (off >= fin) return 16'd6553;
      q = 64'(off);
      q = (q << 16) / fin;
      q = q / 10;
      if (q > 6553) q = 6553;
      return q[15:0];
   endfunction

   function automatic lprc_rsp_type predict_point(input lprc_req_type p);
      lprc_rsp_type o;
      longint sr, cr, sp, cp;
      longint m[3][3];
      longint c[3];
      longint acc[3];
      int     r;
      sr = clamp_angle(mount_sin_roll);
      cr = clamp_angle(mount_cos_roll);
      sp = clamp_angle(mount_sin_pitch);
      cp = clamp_angle(mount_cos_pitch);
      m[0][0] = cp;                  m[0][1] = 0;  m[0][2] = sp;
      m[1][0] = q14_round(sr * sp);  m[1][1] = cr; m[1][2] = q14_round(-(sr * cp));
      m[2][0] = q14_round(-(cr * sp)); m[2][1] = sr; m[2][2] = q14_round(cr * cp);
      c[0] = longint'(p.x_in);
      c[1] = longint'(p.y_in);
      c[2] = longint'(p.z_in);
      for (int i = 0; i < 3; i++)
         acc[i] = q14_round(m[i][0] * c[0] + m[i][1] * c[1] + m[i][2] * c[2]);
      o = '0;
      o.x_out = saturate_coord(acc[0]);
      o.y_out = saturate_coord(acc[1]);
      o.z_out = saturate_coord(acc[2]);
      o.intensity_packed = {p.scan_line, time_frac(p.time_offset, p.frame_end_time)};
      o.reflect_out = p.reflect_in;
      r = p.reflect_in;
      if (colour_on) begin
         if (r < 30) begin
            o.green = 8'(r * 255 / 30); o.blue = 8'd255;
         end else if (r < 90) begin
            o.green = 8'd255; o.blue = 8'((90 - r) * 255 / 60);
         end else if (r < 150) begin
            o.red = 8'((r - 90) * 255 / 60); o.green = 8'd255;
         end else begin
            o.red = 8'd255; o.green = 8'((255 - r) * 255 / 105);
         end
      end
      o.frame_done = p.last_point;
      return o;
   endfunction

   // result side: random stall and in-order compare
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result transfer");
            mismatch_count++;
         end else begin
            lprc_rsp_type e;
            e = pending_points.pop_front();
            points_checked++;
            if (rsp_data.x_out !== e.x_out) begin
               $error("x_out expected %0d got %0d", e.x_out, rsp_data.x_out); mismatch_count++;
            end
            if (rsp_data.y_out !== e.y_out) begin
               $error("y_out expected %0d got %0d", e.y_out, rsp_data.y_out); mismatch_count++;
            end
            if (rsp_data.z_out !== e.z_out) begin
               $error("z_out expected %0d got %0d", e.z_out, rsp_data.z_out); mismatch_count++;
            end
            if (rsp_data.intensity_packed !== e.intensity_packed) begin
               $error("intensity_packed expected %h got %h",
                      e.intensity_packed, rsp_data.intensity_packed);
               mismatch_count++;
            end
            if (rsp_data.reflect_out !== e.reflect_out) begin
               $error("reflect_out expected %0d got %0d", e.reflect_out, rsp_data.reflect_out);
               mismatch_count++;
            end
            if (rsp_data.red !== e.red) begin
               $error("red expected %0d got %0d", e.red, rsp_data.red); mismatch_count++;
            end
            if (rsp_data.green !== e.green) begin
               $error("green expected %0d got %0d", e.green, rsp_data.green); mismatch_count++;
            end
            if (rsp_data.blue !== e.blue) begin
               $error("blue expected %0d got %0d", e.blue, rsp_data.blue); mismatch_count++;
            end
            if (rsp_data.frame_done !== e.frame_done) begin
               $error("frame_done expected %0d got %0d", e.frame_done, rsp_data.frame_done);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 24);
   end

   task automatic send_point(input lprc_req_type p);
      if (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      pending_points.insert(pending_points.size(), predict_point(p));
      points_sent++;
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_points.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SIN_ROLL:      mount_sin_roll = val;
         CSR_COS_ROLL:      mount_cos_roll = val;
         CSR_SIN_PITCH:     mount_sin_pitch = val;
         CSR_COS_PITCH:     mount_cos_pitch = val;
         CSR_COLOUR_ENABLE: colour_on = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_mount(input logic [15:0] sr, cr, sp, cp, input logic en);
      drain_points();
      write_csr(CSR_SIN_ROLL, sr);
      write_csr(CSR_COS_ROLL, cr);
      write_csr(CSR_SIN_PITCH, sp);
      write_csr(CSR_COS_PITCH, cp);
      write_csr(CSR_COLOUR_ENABLE, {15'd0, en});
      settings_used++;
   endtask

   function automatic lprc_req_type random_point();
      lprc_req_type p;
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(lprc_req_type)-1:0];
      case ($urandom_range(3))
         0: begin
            p.x_in = $signed($urandom_range(2000000)) - 1000000;
            p.y_in = $signed($urandom_range(2000000)) - 1000000;
            p.z_in = $signed($urandom_range(2000000)) - 1000000;
         end
         1: p.x_in = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: ;
      endcase
      case ($urandom_range(4))
         0: p.frame_end_time = '0;
         1: p.time_offset = p.frame_end_time + $urandom_range(2);
         2: begin
            p.frame_end_time = $urandom_range(100000, 1);
            p.time_offset = $urandom_range(p.frame_end_time);
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic lprc_req_type make_point(input logic [31:0] x, y, z,
                                               input logic [7:0] line, refl,
                                               input logic [31:0] off, fin,
                                               input logic last);
      return '{x, y, z, line, refl, off, fin, last};
   endfunction

   task automatic test_extremes();
      send_point(make_point(32'h7fffffff, 32'h80000000, 0, 8'hff, 0, 0, 100, 1));
      send_point(make_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 255, 50, 100, 0));
      send_point(make_point(32'h00010000, 32'hffff0000, 32'h12345678, 8'h55, 30, 99, 100, 1));
      set_mount(16'd16384, 16'd0, 16'hc000, 16'd0, 1'b1);
      send_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8'haa, 89, 1, 3, 0));
      send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 1, 90, 7, 11, 1));
      // out of range angle registers are clamped
      set_mount(16'h7fff, 16'h8000, 16'h4001, 16'hbfff, 1'b1);
      send_point(make_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 2, 149, 0, 1, 0));
      send_point(make_point(32'h80000000, 32'h7fffffff, 32'h80000000, 3, 150, 5, 5, 1));
   endtask

   task automatic test_colormap_and_time();
      logic [7:0] refl_marks[10] = '{0, 1, 29, 30, 60, 89, 90, 149, 150, 255};
      set_mount(16'd11585, 16'd11585, 16'hd2bf, 16'd11585, 1'b1);
      foreach (refl_marks[i])
         send_point(make_point($urandom, $urandom, $urandom, 8'(i), refl_marks[i],
                               $urandom, $urandom, i[0]));
      send_point(make_point(1, 2, 3, 4, 5, 1234, 0, 0));
      send_point(make_point(1, 2, 3, 4, 5, 32'hffffffff, 32'hfffffffe, 1));
      send_point(make_point(1, 2, 3, 4, 5, 32'hfffffffe, 32'hffffffff, 0));
      send_point(make_point(1, 2, 3, 4, 5, 0, 32'hffffffff, 1));
      set_mount(16'd0, 16'd16384, 16'd0, 16'd16384, 1'b0);
      send_point(make_point(100, 200, 300, 9, 200, 10, 20, 0));
      drain_points();
      write_csr(3'd5, 16'hffff);
      write_csr(3'd7, 16'h1234);
      send_point(make_point(100, 200, 300, 9, 20, 10, 20, 1));
   endtask

   task automatic test_random_points();
      for (int s = 0; s < 10; s++) begin
         case (s)
            0: set_mount(16'd0, 16'd16384, 16'd0, 16'd16384, 1'b0);
            1: set_mount(16'hc000, 16'hc000, 16'hc000, 16'hc000, 1'b1);
            2: set_mount(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom_range(1)));
            default: set_mount(16'($urandom_range(32768)) - 16'd16384,
                               16'($urandom_range(32768)) - 16'd16384,
                               16'($urandom_range(32768)) - 16'd16384,
                               16'($urandom_range(32768)) - 16'd16384,
                               1'($urandom_range(1)));
         endcase
         calm = (s == 4);
         for (int i = 0; i < 150; i++) begin
            if (s == 6 && i == 75) drain_points();
            send_point(random_point());
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      mount_sin_roll = 0; mount_cos_roll = 16384;
      mount_sin_pitch = 0; mount_cos_pitch = 16384; colour_on = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_colormap_and_time();
      test_random_points();
      drain_points();
      $display("%0d points sent, %0d results checked across %0d mount settings",
               points_sent, points_checked, settings_used);
      $display("covered colormap segments, time fraction limits and coordinate saturation");
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
